>>> hdl/nth_weekday_of_month_finder_macros.svh
// Assertion helpers for the nth weekday finder.
`ifndef NTH_WEEKDAY_OF_MONTH_FINDER_MACROS_SVH
`define NTH_WEEKDAY_OF_MONTH_FINDER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define NWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Delayed implication, disabled while reset is active.
`define NWF_ASSERT_LAT5(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##5 (cons)) \
		else $error(msg);

`endif

>>> hdl/nwf_pkg.sv
package nwf_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int WDAY_W  = 3;
	localparam int OCC_W   = 4;
	localparam int DAY_W   = 5;

	// Adjusted year plus a bias, always non-negative.
	localparam int YADJ_W  = 15;
	localparam int QPROD_W = 30;
	localparam int PPROD_W = 26;
	localparam int SUM_W   = 24;
	localparam int MTERM_W = 9;
	localparam int CENT_W  = 8;

	// floor(v/100) = (v * DIV100_MUL) >> DIV100_SHIFT, exact for v < 43690
	localparam logic [YADJ_W-1:0]  DIV100_MUL   = 15'd20972;
	localparam int                 DIV100_SHIFT = 21;
	localparam logic [YADJ_W-1:0]  CENT_BIAS    = 15'd100;
	localparam logic [YADJ_W-1:0]  YEAR_BIAS    = 15'd4716;
	localparam logic [10:0]        JD_YEAR_MUL  = 11'd1461;
	// Collects -1523 + 1 + 2 - 1 + ... of the day formula after the century bias.
	localparam logic [SUM_W-1:0]   SUM_BIAS     = 24'd1520;
	localparam logic [DAY_W-1:0]   LAST_DAY     = 5'd31;
	localparam logic [WDAY_W-1:0]  NO_WEEKDAY   = 3'd7;

	typedef struct packed {
		logic               valid;
		logic [WDAY_W-1:0]  wanted_weekday;
		logic [OCC_W-1:0]   occurrence;
	} nwf_tag_t;

	// floor(30.6001*(M+1)) for the adjusted month of each raw month code
	function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] m);
		logic [MTERM_W-1:0] t;
		case (m)
			4'd0:    t = 9'd397;
			4'd1:    t = 9'd428;
			4'd2:    t = 9'd459;
			4'd3:    t = 9'd122;
			4'd4:    t = 9'd153;
			4'd5:    t = 9'd183;
			4'd6:    t = 9'd214;
			4'd7:    t = 9'd244;
			4'd8:    t = 9'd275;
			4'd9:    t = 9'd306;
			4'd10:   t = 9'd336;
			4'd11:   t = 9'd367;
			4'd12:   t = 9'd397;
			4'd13:   t = 9'd428;
			4'd14:   t = 9'd459;
			default: t = 9'd489;
		endcase
		return t;
	endfunction

	// 8 == 1 mod 7: fold octal digits, then trim.
	function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] v);
		logic [5:0] s;
		logic [3:0] d;
		logic [3:0] r;
		s = '0;
		for (int i = 0; i < SUM_W / 3; i++) begin
			s = s + 6'(v[i*3 +: 3]);
		end
		d = 4'(s[5:3]) + 4'(s[2:0]);
		if (d >= 4'd14) begin
			r = d - 4'd14;
		end else if (d >= 4'd7) begin
			r = d - 4'd7;
		end else begin
			r = d;
		end
		return r[WDAY_W-1:0];
	endfunction

endpackage

>>> hdl/nwf_jd.sv
module nwf_jd import nwf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [YEAR_W-1:0]   year,
	input  logic [MONTH_W-1:0]  month,
	input  logic [WDAY_W-1:0]   wanted_weekday,
	input  logic [OCC_W-1:0]    occurrence,
	output logic [SUM_W-1:0]    sum_s3,
	output nwf_tag_t            tag_s3
);

	nwf_tag_t             tag_s1, tag_s2;
	logic [YADJ_W-1:0]    ycent_s1, yjd_s1;
	logic [MTERM_W-1:0]   mterm_s1, mterm_s2;
	logic [QPROD_W-1:0]   qprod_s2;
	logic [PPROD_W-1:0]   pprod_s2;

	logic [YADJ_W-1:0]    yadj;
	logic [CENT_W-1:0]    cent;
	logic [SUM_W-1:0]     pterm;
	logic [CENT_W-1:0]    cent_q4;

	// January and February count as months 13 and 14 of the year before.
	assign yadj = YADJ_W'(year) - YADJ_W'(month <= 4'd2);

	// cent is floor(y/100) + 1, so the year -1 case stays non-negative.
	assign cent    = qprod_s2[DIV100_SHIFT +: CENT_W];
	assign cent_q4 = 8'((9'(cent) + 9'd3) >> 2);
	assign pterm   = pprod_s2[2 +: SUM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= '{valid: in_valid, wanted_weekday: wanted_weekday,
				occurrence: occurrence};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		ycent_s1 <= yadj + CENT_BIAS;
		yjd_s1   <= yadj + YEAR_BIAS;
		mterm_s1 <= month_term(month);

		qprod_s2 <= QPROD_W'(ycent_s1) * QPROD_W'(DIV100_MUL);
		pprod_s2 <= PPROD_W'(yjd_s1) * PPROD_W'(JD_YEAR_MUL);
		mterm_s2 <= mterm_s1;

		sum_s3 <= pterm + SUM_W'(mterm_s2) + SUM_W'(cent_q4) - SUM_W'(cent) - SUM_BIAS;
	end

endmodule

>>> hdl/nwf_dow.sv
module nwf_dow import nwf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SUM_W-1:0]   sum_s3,
	input  nwf_tag_t           tag_s3,
	output logic [WDAY_W-1:0]  dow_s4,
	output nwf_tag_t           tag_s4
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else begin
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		dow_s4 <= mod7(sum_s3);
	end

endmodule

>>> hdl/nwf_pick.sv
module nwf_pick import nwf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [WDAY_W-1:0]  dow_s4,
	input  nwf_tag_t           tag_s4,
	output logic               done,
	output logic [DAY_W-1:0]   day_of_month,
	output logic               found
);

	logic              done_s5, found_s5;
	logic [DAY_W-1:0]  day_s5;

	logic [3:0]        diff;
	logic [2:0]        offset;
	logic [OCC_W-1:0]  occ_m1;
	logic [6:0]        weeks7;
	logic [6:0]        day_full;
	logic              hit;

	// Days from day 1 to the first wanted weekday, then whole weeks after it.
	assign diff     = 4'(tag_s4.wanted_weekday) + 4'd7 - 4'(dow_s4);
	assign offset   = (diff >= 4'd7) ? 3'(diff - 4'd7) : diff[2:0];
	assign occ_m1   = tag_s4.occurrence - 4'd1;
	assign weeks7   = {occ_m1, 3'b000} - 7'(occ_m1);
	assign day_full = 7'd1 + 7'(offset) + weeks7;

	always_comb begin
		if (tag_s4.occurrence == '0) begin
			hit = 1'b1;
		end else if (tag_s4.wanted_weekday == NO_WEEKDAY) begin
			hit = 1'b0;
		end else begin
			hit = (day_full <= 7'(LAST_DAY));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= tag_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		found_s5 <= hit;
		if (tag_s4.occurrence == '0) begin
			day_s5 <= DAY_W'(1);
		end else if (hit) begin
			day_s5 <= day_full[DAY_W-1:0];
		end else begin
			day_s5 <= '0;
		end
	end

	assign done         = done_s5;
	assign day_of_month = day_s5;
	assign found        = found_s5;

endmodule

>>> hdl/nth_weekday_of_month_finder.sv
// Finds the day of the month on which the n-th given weekday falls, scanning days 1..31
// without regard to month length; occurrence 0 yields day 1. A request beat is taken
// whenever start is high (busy stays low: a new request can enter every cycle) and its
// result shows on done, day_of_month and found once it has passed the pipeline, for one cycle.
// The receiver cannot stall; results must be taken as they appear. The pipeline stages are,
// in order: year adjust, the two constant multiplies of the Julian day, the day sum,
// the mod-7 fold, and the day pick.
`include "nth_weekday_of_month_finder_macros.svh"

module nth_weekday_of_month_finder import nwf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [YEAR_W-1:0]   year,
	input  logic [MONTH_W-1:0]  month,
	input  logic [WDAY_W-1:0]   wanted_weekday,
	input  logic [OCC_W-1:0]    occurrence,
	output logic                done,
	output logic [DAY_W-1:0]    day_of_month,
	output logic                found
);

	logic [SUM_W-1:0]   sum_s3;
	nwf_tag_t           tag_s3, tag_s4;
	logic [WDAY_W-1:0]  dow_s4;

	assign busy = 1'b0;

	nwf_jd u_jd (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start & ~busy),
		.year           (year),
		.month          (month),
		.wanted_weekday (wanted_weekday),
		.occurrence     (occurrence),
		.sum_s3         (sum_s3),
		.tag_s3         (tag_s3)
	);

	nwf_dow u_dow (
		.clk    (clk),
		.arst_n (arst_n),
		.sum_s3 (sum_s3),
		.tag_s3 (tag_s3),
		.dow_s4 (dow_s4),
		.tag_s4 (tag_s4)
	);

	nwf_pick u_pick (
		.clk          (clk),
		.arst_n       (arst_n),
		.dow_s4       (dow_s4),
		.tag_s4       (tag_s4),
		.done         (done),
		.day_of_month (day_of_month),
		.found        (found)
	);

	`NWF_ASSERT_LAT5(a_lat_start, clk, arst_n, start, done, "result missing after request")
	`NWF_ASSERT_LAT5(a_lat_idle, clk, arst_n, !start, !done, "result without a request")
	`NWF_ASSERT_LAT5(a_occ_zero, clk, arst_n, start && (occurrence == 4'd0),
		done && found && (day_of_month == 5'd1), "occurrence zero must give day 1")
	`NWF_ASSERT_IMP(a_found_day, clk, arst_n, done,
		found == (day_of_month != 5'd0), "found disagrees with day")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench import nwf_pkg::*;;

	localparam int RANDOM_REQUESTS = 750;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int SETTLE_CYCLES   = 20;

	typedef enum logic [WDAY_W-1:0] {
		SUNDAY, MONDAY, TUESDAY, WEDNESDAY, THURSDAY, FRIDAY, SATURDAY
	} weekday_t;

	typedef struct {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [WDAY_W-1:0]  wday;
		logic [OCC_W-1:0]   occ;
		bit                 drain;
	} calendar_request_t;

	typedef struct {
		calendar_request_t  rq;
		logic [DAY_W-1:0]   day;
		logic               found;
	} day_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [YEAR_W-1:0]  year = '0;
	logic [MONTH_W-1:0] month = '0;
	logic [WDAY_W-1:0]  wanted_weekday = '0;
	logic [OCC_W-1:0]   occurrence = '0;
	logic               done;
	logic [DAY_W-1:0]   day_of_month;
	logic               found;

	calendar_request_t  request_queue[$];
	day_answer_t        answer_queue[$];
	calendar_request_t  driven_rq;
	bit                 beat_taken = 1'b0;
	int                 gap_left = 0;
	int                 burst_left = 0;
	int                 failures = 0;
	int                 matched = 0;
	int                 found_seen = 0;
	int                 missing_seen = 0;
	int                 cycle_count = 0;
	int                 directed_count = 0;

	nth_weekday_of_month_finder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.year          (year),
		.month         (month),
		.wanted_weekday(wanted_weekday),
		.occurrence    (occurrence),
		.done          (done),
		.day_of_month  (day_of_month),
		.found         (found)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Integer division rounding toward minus infinity.
	function automatic longint floor_quot(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b != 0) && ((a < 0) != (b < 0)))
			q = q - 1;
		return q;
	endfunction

	function automatic day_answer_t find_nth_weekday(input calendar_request_t rq);
		day_answer_t ans;
		longint      y;
		longint      m;
		longint      cent;
		longint      jd;
		int          dow;
		int          day;
		int          left;
		y = rq.year;
		m = rq.month;
		// January and February belong to the year before
		if (m <= 2) begin
			y = y - 1;
			m = m + 12;
		end
		cent = floor_quot(y, 100);
		jd = floor_quot(1461 * (y + 4716), 4) + floor_quot(306001 * (m + 1), 10000)
			+ 1 + (2 - cent + floor_quot(cent, 4)) - 1523;
		dow = int'(jd % 7);
		if (dow < 0)
			dow = dow + 7;
		day = 1;
		left = rq.occ;
		while (day <= 31 && left > 0) begin
			if (dow == int'(rq.wday)) begin
				left = left - 1;
				if (left == 0)
					break;
			end
			day = day + 1;
			dow = (dow + 1) % 7;
		end
		ans.rq = rq;
		if (day <= 31) begin
			ans.day = DAY_W'(day);
			ans.found = 1'b1;
		end else begin
			ans.day = '0;
			ans.found = 1'b0;
		end
		return ans;
	endfunction

	task automatic add_request(input int y, input int m, input int w, input int o,
			input bit drain);
		calendar_request_t rq;
		rq.year = YEAR_W'(y);
		rq.month = MONTH_W'(m);
		rq.wday = WDAY_W'(w);
		rq.occ = OCC_W'(o);
		rq.drain = drain;
		request_queue.push_back(rq);
	endtask

	// Driver: hold a beat until taken, then idle or present the next request.
	always @(negedge clk) begin
		if (arst_n && (!start || beat_taken)) begin
			beat_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				start <= 1'b0;
			end else if (request_queue.size() != 0 &&
					(!request_queue[0].drain || answer_queue.size() == 0)) begin
				driven_rq = request_queue.pop_front();
				start <= 1'b1;
				year <= driven_rq.year;
				month <= driven_rq.month;
				wanted_weekday <= driven_rq.wday;
				occurrence <= driven_rq.occ;
				if (burst_left > 0) begin
					burst_left = burst_left - 1;
					gap_left = 0;
				end else begin
					case ($urandom_range(0, 99)) inside
						[0:54]:  gap_left = 0;
						[55:84]: gap_left = $urandom_range(1, 3);
						[85:94]: gap_left = $urandom_range(4, 9);
						[95:97]: gap_left = $urandom_range(20, 60);
						default: burst_left = $urandom_range(20, 60);
					endcase
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: record each taken beat, then check the result strobe.
	always @(posedge clk) begin
		day_answer_t want;
		if (arst_n) begin
			if (start && !busy) begin
				answer_queue.push_back(find_nth_weekday(driven_rq));
				beat_taken = 1'b1;
			end
			if (done) begin
				if (answer_queue.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result: day %0d found %0b", day_of_month, found);
				end else begin
					want = answer_queue.pop_front();
					if (day_of_month !== want.day || found !== want.found) begin
						failures++;
						if (failures <= 10)
							$display("mismatch y=%0d m=%0d wd=%0d n=%0d exp %0d/%0b got %0d/%0b",
								want.rq.year, want.rq.month, want.rq.wday, want.rq.occ,
								want.day, want.found, day_of_month, found);
					end else begin
						matched++;
						if (want.found)
							found_seen++;
						else
							missing_seen++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				answer_queue.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int  pick;
		bit  drain;
		// range corners and the year before year one
		add_request(1, 1, SUNDAY, 1, 1'b0);
		add_request(9999, 12, SATURDAY, 5, 1'b0);
		add_request(0, 1, WEDNESDAY, 1, 1'b0);
		add_request(0, 2, THURSDAY, 2, 1'b0);
		add_request(0, 3, FRIDAY, 3, 1'b0);
		add_request(0, 0, MONDAY, 2, 1'b0);
		add_request(16383, 15, NO_WEEKDAY, 0, 1'b0);
		add_request(16383, 0, TUESDAY, 15, 1'b0);
		// occurrence zero, occurrences past day 31, weekday seven
		add_request(2024, 2, THURSDAY, 0, 1'b0);
		add_request(2024, 6, SUNDAY, 15, 1'b0);
		add_request(2023, 5, NO_WEEKDAY, 1, 1'b0);
		add_request(2023, 4, MONDAY, 5, 1'b0);
		// century rules and month zero
		add_request(2000, 3, MONDAY, 1, 1'b0);
		add_request(1900, 3, TUESDAY, 4, 1'b0);
		add_request(1582, 10, FRIDAY, 2, 1'b0);
		add_request(4, 0, SATURDAY, 5, 1'b0);
		add_request(100, 7, WEDNESDAY, 5, 1'b0);
		// years beyond 9999 and months 13 and 14
		add_request(10000, 13, MONDAY, 3, 1'b0);
		add_request(12000, 14, TUESDAY, 2, 1'b0);
		add_request(9999, 1, SUNDAY, 4, 1'b0);
		add_request(8192, 9, THURSDAY, 3, 1'b0);
		add_request(5461, 10, TUESDAY, 1, 1'b0);
		add_request(10922, 5, FRIDAY, 5, 1'b1);
		directed_count = request_queue.size();
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			pick = $urandom_range(0, 99);
			drain = (i == RANDOM_REQUESTS / 2) || ($urandom_range(0, 99) == 0);
			if (pick < 80)
				add_request($urandom_range(1, 9999), $urandom_range(1, 12),
					$urandom_range(0, 6), $urandom_range(0, 6), drain);
			else
				add_request($urandom_range(0, 16383), $urandom_range(0, 15),
					$urandom_range(0, 7), $urandom_range(0, 15), drain);
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (request_queue.size() != 0 || start || answer_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d requests (%0d directed); %0d results matched.",
			directed_count + RANDOM_REQUESTS, directed_count, matched);
		$display("Of those, %0d landed on a day and %0d ran past day 31.",
			found_seen, missing_seen);
		if (failures == 0 && answer_queue.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d failures", failures);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/nwf_pkg.sv
hdl/nwf_jd.sv
hdl/nwf_dow.sv
hdl/nwf_pick.sv
hdl/nth_weekday_of_month_finder.sv
verif/testbench.sv
